FILE: sv/gsc_pkg.sv
// ----------------------------------------------------------------------------
// gsc_pkg
// Shared types and codes for the glyph slot cache.
// ----------------------------------------------------------------------------
package gsc_pkg;

   localparam int CODE_W = 16;

   // item kinds
   localparam logic [1:0] KIND_LOOKUP    = 2'd0;
   localparam logic [1:0] KIND_BEGIN     = 2'd1;
   localparam logic [1:0] KIND_EVICT     = 2'd2;
   localparam logic [1:0] KIND_RESET_ALL = 2'd3;

   // result status codes
   localparam logic [2:0] STATUS_HIT     = 3'd0;
   localparam logic [2:0] STATUS_ALLOC   = 3'd1;
   localparam logic [2:0] STATUS_MISSING = 3'd2;
   localparam logic [2:0] STATUS_FULL    = 3'd3;
   localparam logic [2:0] STATUS_DONE    = 3'd4;

   localparam logic [8:0] RASTER_ENTRIES = 9'd256;
   localparam logic [7:0] ROW_MASK       = 8'hF0;

   typedef enum logic [1:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_SCAN,
      FSM_RESULT
   } fsm_state_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] slot;
      logic [7:0] tile_u;
      logic [7:0] tile_v;
      logic [5:0] upload_x;
      logic [7:0] raster_index;
   } result_type;

endpackage

FILE: sv/glyph_slot_cache_with_frame_eviction.sv
// ----------------------------------------------------------------------------
// glyph_slot_cache_with_frame_eviction
// Fully associative glyph slot cache with per-frame used bits, kept in one
// synchronous slot memory and walked by a pipelined read-modify-write scan.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                               | tuser
//  req     | in        | glyph_code, glyph_present           | kind
//  rsp     | out       | slot, tile_u, tile_v, upload_x,     | status
//          |           | raster_index                        |
//
//  Every item walks the slot memory through its single read port, one slot
//  per cycle: a maintenance item or a lookup without a hit walks every slot,
//  and a lookup that hits slot i stops there; no new item is accepted during
//  the walk. After reset a clearing pass zeroes the slots while req_tready
//  stays low. A result waits in the output register; the next item is
//  accepted meanwhile, and its result holds until the earlier one is taken.
// ----------------------------------------------------------------------------
module glyph_slot_cache_with_frame_eviction
   import gsc_pkg::*;
#(
   parameter int SLOT_COUNT   = 256,
   parameter int TILE_COLUMNS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] glyph_code, [16] glyph_present, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] slot, [15:8] tile_u, [23:16] tile_v,
                                    // [29:24] upload_x, [37:30] raster_index, rest zero
   output logic [2:0]  rsp_tuser    // [2:0] status
);

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam int COL_W = (TILE_COLUMNS > 1) ? $clog2(TILE_COLUMNS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(TILE_COLUMNS - 1);
   localparam int ENTRY_W = CODE_W + 1;

   // slot memory: {code, used}
   logic [ENTRY_W-1:0] mem [SLOT_COUNT];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               rd_en;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;

   fsm_state_type state_ff, state_in;

   logic [1:0]        kind_ff, kind_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic              present_ff, present_in;

   logic              iss_active_ff, iss_active_in;
   logic [IDX_W-1:0]  iss_idx_ff, iss_idx_in;
   logic [COL_W-1:0]  iss_col_ff, iss_col_in;

   logic              chk_valid_ff, chk_valid_in;
   logic              chk_last_ff, chk_last_in;
   logic [IDX_W-1:0]  chk_idx_ff, chk_idx_in;
   logic [COL_W-1:0]  chk_col_ff, chk_col_in;

   logic              free_found_ff, free_found_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic [COL_W-1:0]  free_col_ff, free_col_in;

   logic [8:0]        raster_next_ff, raster_next_in;

   result_type        res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff, rsp_in;

   logic [CODE_W-1:0] entry_code;
   logic              entry_used;
   logic              chk_hit;
   logic              chk_free;
   logic              scan_end;
   logic              req_accept;
   logic              rsp_free;

   assign entry_code = rd_data_ff[ENTRY_W-1:1];
   assign entry_used = rd_data_ff[0];
   assign chk_hit    = chk_valid_ff && (kind_ff == KIND_LOOKUP) && (entry_code == code_ff);
   assign chk_free   = chk_valid_ff && (entry_code == '0) && !entry_used;
   assign scan_end   = chk_valid_ff && (chk_hit || chk_last_ff);
   assign req_tready = (state_ff == FSM_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // ---- next state ----
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_CLEAR: begin
            if (scan_end) state_in = FSM_IDLE;
         end
         FSM_IDLE: begin
            if (req_accept) state_in = FSM_SCAN;
         end
         FSM_SCAN: begin
            if (scan_end) state_in = FSM_RESULT;
         end
         FSM_RESULT: begin
            if (rsp_free) state_in = FSM_IDLE;
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // ---- datapath and memory control ----
   always_comb begin
      logic              use_alloc;
      logic [IDX_W-1:0]  sel_idx;
      logic [COL_W-1:0]  sel_col;
      logic [31:0]       slot32;
      logic [31:0]       u32;
      logic [31:0]       x32;
      logic [7:0]        slot8;
      logic [7:0]        raster8;

      kind_in        = kind_ff;
      code_in        = code_ff;
      present_in     = present_ff;
      iss_active_in  = iss_active_ff;
      iss_idx_in     = iss_idx_ff;
      iss_col_in     = iss_col_ff;
      chk_valid_in   = 1'b0;
      chk_last_in    = chk_last_ff;
      chk_idx_in     = chk_idx_ff;
      chk_col_in     = chk_col_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      free_col_in    = free_col_ff;
      raster_next_in = raster_next_ff;
      res_in         = res_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_in         = rsp_ff;
      rd_en          = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = chk_idx_ff;
      wr_data        = rd_data_ff;

      use_alloc = 1'b0;
      sel_idx   = chk_idx_ff;
      sel_col   = chk_col_ff;
      if (!chk_hit && free_found_ff) begin
         sel_idx = free_idx_ff;
         sel_col = free_col_ff;
      end else if (!chk_hit && chk_free) begin
         sel_idx = chk_idx_ff;
         sel_col = chk_col_ff;
      end
      slot32  = 32'(sel_idx);
      u32     = 32'(sel_col) << 4;
      x32     = 32'(sel_col) << 2;
      slot8   = slot32[7:0];
      raster8 = (raster_next_ff >= RASTER_ENTRIES) ? 8'(RASTER_ENTRIES - 9'd1)
                                                   : raster_next_ff[7:0];

      // start an item
      if (req_accept) begin
         kind_in       = req_tuser;
         code_in       = req_tdata[15:0];
         present_in    = req_tdata[16];
         iss_active_in = 1'b1;
         iss_idx_in    = '0;
         iss_col_in    = '0;
         free_found_in = 1'b0;
         if (req_tuser == KIND_BEGIN) raster_next_in = '0;
      end

      // issue one slot read a cycle
      if ((state_ff == FSM_CLEAR || state_ff == FSM_SCAN) && iss_active_ff) begin
         rd_en         = 1'b1;
         chk_valid_in  = 1'b1;
         chk_idx_in    = iss_idx_ff;
         chk_col_in    = iss_col_ff;
         chk_last_in   = (iss_idx_ff == LAST_IDX);
         iss_idx_in    = iss_idx_ff + 1'b1;
         iss_col_in    = (iss_col_ff == LAST_COL) ? '0 : iss_col_ff + 1'b1;
         iss_active_in = (iss_idx_ff != LAST_IDX);
      end

      // check the slot read last cycle and write it back as its item kind requires
      if ((state_ff == FSM_CLEAR || state_ff == FSM_SCAN) && chk_valid_ff) begin
         case (kind_ff)
            KIND_LOOKUP: begin
               if (chk_hit) begin
                  wr_en   = 1'b1;
                  wr_data = {entry_code, 1'b1};
               end else if (chk_free && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = chk_idx_ff;
                  free_col_in   = chk_col_ff;
               end
            end
            KIND_BEGIN: begin
               wr_en   = 1'b1;
               wr_data = {entry_code, 1'b0};
            end
            KIND_EVICT: begin
               wr_en   = 1'b1;
               wr_data = entry_used ? rd_data_ff : '0;
            end
            KIND_RESET_ALL: begin
               wr_en   = 1'b1;
               wr_data = '0;
            end
            default: wr_en = 1'b0;
         endcase

         if (scan_end) begin
            iss_active_in = 1'b0;
            chk_valid_in  = 1'b0;
            res_in        = '0;
            if (kind_ff != KIND_LOOKUP) begin
               res_in.status = STATUS_DONE;
            end else if (chk_hit) begin
               res_in.status = STATUS_HIT;
            end else if (!present_ff) begin
               res_in.status = STATUS_MISSING;
            end else if (free_found_ff || chk_free) begin
               use_alloc     = 1'b1;
               res_in.status = STATUS_ALLOC;
            end else begin
               res_in.status = STATUS_FULL;
            end

            if (chk_hit || use_alloc) begin
               res_in.slot   = slot8;
               res_in.tile_u = u32[7:0];
               res_in.tile_v = slot8 & ROW_MASK;
            end
            if (use_alloc) begin
               res_in.upload_x     = x32[5:0];
               res_in.raster_index = raster8;
               wr_en   = 1'b1;
               wr_addr = sel_idx;
               wr_data = {code_ff, 1'b1};
               if (raster_next_ff < RASTER_ENTRIES) raster_next_in = raster_next_ff + 9'd1;
            end
         end
      end

      // hand the result to the output register
      if (state_ff == FSM_RESULT && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res_ff;
      end
   end

   // ---- slot memory ----
   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[iss_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   // ---- control registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= FSM_CLEAR;
         kind_ff        <= KIND_RESET_ALL;
         iss_active_ff  <= 1'b1;
         iss_idx_ff     <= '0;
         iss_col_ff     <= '0;
         chk_valid_ff   <= 1'b0;
         free_found_ff  <= 1'b0;
         raster_next_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         kind_ff        <= kind_in;
         iss_active_ff  <= iss_active_in;
         iss_idx_ff     <= iss_idx_in;
         iss_col_ff     <= iss_col_in;
         chk_valid_ff   <= chk_valid_in;
         free_found_ff  <= free_found_in;
         raster_next_ff <= raster_next_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // ---- payload registers ----
   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      present_ff  <= present_in;
      chk_last_ff <= chk_last_in;
      chk_idx_ff  <= chk_idx_in;
      chk_col_ff  <= chk_col_in;
      free_idx_ff <= free_idx_in;
      free_col_ff <= free_col_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {2'b00, rsp_ff.raster_index, rsp_ff.upload_x, rsp_ff.tile_v,
                        rsp_ff.tile_u, rsp_ff.slot};

endmodule

FILE: tb/sv/tb_glyph_slot_cache_with_frame_eviction.sv
// ----------------------------------------------------------------------------
// tb_glyph_slot_cache_with_frame_eviction
// Drives lookup, begin-frame, evict and reset-all items into the glyph slot
// cache and checks every result against a cycle-free model of the slot
// table. Random frames mix hits, fresh glyphs, code zero and missing glyphs;
// two long frames look up 249 fresh glyphs after a reset-all and run the raster
// counter past its last entry.
// ----------------------------------------------------------------------------
module tb_glyph_slot_cache_with_frame_eviction;
   import gsc_pkg::*;

   localparam int SLOT_N      = 256;
   localparam int TILE_COLS   = 16;
   localparam int ITEM_TARGET = 1150;
   localparam int SETTLE      = 300;
   localparam int STALL_LIMIT = 4000;

   typedef struct {
      logic [1:0]  kind;
      logic [15:0] code;
      logic        present;
      bit          drain;
   } glyph_item_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // [15:0] glyph_code, [16] glyph_present
   logic [1:0]  req_tuser  = '0;   // [1:0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [39:0] rsp_tdata;         // [7:0] slot, [15:8] tile_u, [23:16] tile_v,
                                   // [29:24] upload_x, [37:30] raster_index
   logic [2:0]  rsp_tuser;         // [2:0] status

   glyph_item_type item_q[$];
   glyph_item_type cur_item;
   result_type  rsp_expect_q[$];
   logic [15:0] code_pool[$];

   // slot table mirror
   logic [15:0] slot_code_m [SLOT_N];
   logic        slot_used_m [SLOT_N];
   logic [8:0]  raster_next_m;

   int  items_sent   = 0;
   int  results_seen = 0;
   int  mismatch_count = 0;
   int  quiet_cycles = 0;
   int  send_gap = 0;
   int  recv_gap = 0;
   bit  send_idle_on = 1'b1;
   bit  recv_idle_on = 1'b1;

   glyph_slot_cache_with_frame_eviction dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic int pick_idle(bit idle_on);
      return idle_on ? int'($urandom_range(0, 11)) : 0;
   endfunction

   function automatic result_type tile_of(int s);
      result_type r;
      r = '0;
      r.slot   = 8'(s);
      r.tile_u = 8'((s % TILE_COLS) * 16);
      r.tile_v = 8'(s) & ROW_MASK;
      return r;
   endfunction

   // Apply one item to the mirror and return the result it must produce.
   function automatic result_type cache_predict(logic [1:0] kind, logic [15:0] code,
                                                logic present);
      result_type r;
      int hit_at;
      int free_at;
      r = '0;
      r.status = STATUS_DONE;
      case (kind)
         KIND_BEGIN: begin
            for (int i = 0; i < SLOT_N; i++) slot_used_m[i] = 1'b0;
            raster_next_m = '0;
         end
         KIND_EVICT: begin
            for (int i = 0; i < SLOT_N; i++)
               if (!slot_used_m[i]) slot_code_m[i] = '0;
         end
         KIND_RESET_ALL: begin
            for (int i = 0; i < SLOT_N; i++) begin
               slot_code_m[i] = '0;
               slot_used_m[i] = 1'b0;
            end
         end
         default: begin
            hit_at = -1;
            for (int i = 0; i < SLOT_N && hit_at < 0; i++)
               if (slot_code_m[i] == code) hit_at = i;
            if (hit_at >= 0) begin
               slot_used_m[hit_at] = 1'b1;
               r = tile_of(hit_at);
               r.status = STATUS_HIT;
            end else if (!present) begin
               r.status = STATUS_MISSING;
            end else begin
               free_at = -1;
               for (int i = 0; i < SLOT_N && free_at < 0; i++)
                  if (slot_code_m[i] == '0 && !slot_used_m[i]) free_at = i;
               if (free_at < 0) begin
                  r.status = STATUS_FULL;
               end else begin
                  slot_code_m[free_at] = code;
                  slot_used_m[free_at] = 1'b1;
                  r = tile_of(free_at);
                  r.status = STATUS_ALLOC;
                  r.upload_x = 6'((free_at % TILE_COLS) * 4);
                  // raster counter saturates; the last entry is reused
                  if (raster_next_m >= RASTER_ENTRIES) begin
                     r.raster_index = 8'(RASTER_ENTRIES - 1);
                  end else begin
                     r.raster_index = raster_next_m[7:0];
                     raster_next_m = raster_next_m + 1'b1;
                  end
               end
            end
         end
      endcase
      return r;
   endfunction

   task automatic add_item(logic [1:0] kind, logic [15:0] code, logic present, bit drain);
      glyph_item_type it;
      it.kind = kind;
      it.code = code;
      it.present = present;
      it.drain = drain;
      item_q.push_back(it);
   endtask

   task automatic add_noise_maint(logic [1:0] kind, bit drain);
      add_item(kind, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)), drain);
   endtask

   function automatic logic [15:0] fresh_code();
      logic [15:0] c;
      c = 16'($urandom_range(1, 65535));
      code_pool.push_back(c);
      if (code_pool.size() > 48) void'(code_pool.pop_front());
      return c;
   endfunction

   task automatic play_frame();
      int n;
      int pick;
      logic [15:0] c;
      if ($urandom_range(0, 9) != 0) add_noise_maint(KIND_BEGIN, $urandom_range(0, 9) == 0);
      n = $urandom_range(5, 40);
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < 45 && code_pool.size() != 0)
            c = code_pool[$urandom_range(0, code_pool.size() - 1)];
         else if (pick < 50)
            c = '0;
         else
            c = fresh_code();
         add_item(KIND_LOOKUP, c, $urandom_range(0, 99) < 85, 1'b0);
      end
      repeat ($urandom_range(0, 2))
         add_noise_maint(2'($urandom_range(0, 3)), 1'b0);
      if ($urandom_range(0, 9) < 7) add_noise_maint(KIND_EVICT, 1'b0);
      if ($urandom_range(0, 19) == 0) add_noise_maint(KIND_RESET_ALL, 1'b0);
   endtask

   // Look up 249 fresh glyphs in one frame, then clear the slots without
   // rewinding the raster counter so that allocations reuse its last entry.
   task automatic fill_and_overflow();
      add_noise_maint(KIND_BEGIN, 1'b1);
      add_noise_maint(KIND_RESET_ALL, 1'b0);
      for (int k = 0; k < 280; k++) begin
         if (k % 9 == 8)
            add_item(KIND_LOOKUP, code_pool[$urandom_range(0, code_pool.size() - 1)],
                     1'($urandom_range(0, 1)), 1'b0);
         else
            add_item(KIND_LOOKUP, fresh_code(), 1'b1, 1'b0);
      end
      add_item(KIND_LOOKUP, fresh_code(), 1'b0, 1'b0);
      add_noise_maint(KIND_RESET_ALL, 1'b0);
      repeat (12) add_item(KIND_LOOKUP, fresh_code(), 1'b1, 1'b0);
      add_noise_maint(KIND_BEGIN, 1'b0);
      add_noise_maint(KIND_EVICT, 1'b0);
   endtask

   // stimulus and end of run
   initial begin
      int frame_no;
      for (int i = 0; i < SLOT_N; i++) begin
         slot_code_m[i] = '0;
         slot_used_m[i] = 1'b0;
      end
      raster_next_m = '0;

      add_item(KIND_LOOKUP, 16'h0000, 1'b1, 1'b0);   // code zero hits a free slot
      add_item(KIND_LOOKUP, 16'hFFFF, 1'b1, 1'b0);
      add_item(KIND_LOOKUP, 16'hFFFF, 1'b0, 1'b0);
      add_item(KIND_LOOKUP, 16'h8001, 1'b0, 1'b0);   // missing glyph
      add_item(KIND_LOOKUP, 16'h7FFE, 1'b1, 1'b0);
      add_item(KIND_LOOKUP, 16'h0000, 1'b0, 1'b0);
      add_item(KIND_BEGIN,  16'hFFFF, 1'b1, 1'b0);
      add_item(KIND_LOOKUP, 16'h7FFE, 1'b1, 1'b0);
      add_item(KIND_EVICT,  16'h0000, 1'b0, 1'b0);
      add_item(KIND_LOOKUP, 16'hFFFF, 1'b1, 1'b0);   // lands in the unused zero slot
      add_item(KIND_LOOKUP, 16'h0000, 1'b1, 1'b0);   // hits the evicted slot
      add_item(KIND_RESET_ALL, 16'hA5A5, 1'b1, 1'b1);
      add_item(KIND_LOOKUP, 16'h5555, 1'b1, 1'b0);
      add_item(KIND_LOOKUP, 16'hAAAA, 1'b1, 1'b0);
      add_item(KIND_LOOKUP, 16'h0001, 1'b1, 1'b0);
      add_item(KIND_LOOKUP, 16'h8000, 1'b1, 1'b0);
      add_item(KIND_LOOKUP, 16'h5555, 1'b0, 1'b0);
      add_item(KIND_BEGIN,  16'h0000, 1'b0, 1'b0);
      add_item(KIND_EVICT,  16'hFFFF, 1'b1, 1'b0);
      add_item(KIND_LOOKUP, 16'h5555, 1'b0, 1'b0);
      add_item(KIND_LOOKUP, 16'hAAAA, 1'b1, 1'b0);
      add_item(KIND_RESET_ALL, 16'h0000, 1'b0, 1'b0);

      frame_no = 0;
      while (item_q.size() < ITEM_TARGET) begin
         if (frame_no == 2 || frame_no == 12) fill_and_overflow();
         else play_frame();
         frame_no++;
      end

      @(negedge reset);
      while (item_q.size() != 0 || req_tvalid || items_sent != results_seen)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (rsp_expect_q.size() != 0) begin
         $display("%0d results never arrived", rsp_expect_q.size());
         mismatch_count += rsp_expect_q.size();
      end
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // request driver
   always @(posedge clock) begin : drive_req
      bit took;
      int in_flight;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         took = req_tvalid && req_tready;
         if (took) begin
            rsp_expect_q.push_back(cache_predict(cur_item.kind, cur_item.code,
                                                 cur_item.present));
            items_sent <= items_sent + 1;
            send_gap = pick_idle(send_idle_on);
            if ($urandom_range(0, 63) == 0) send_idle_on = !send_idle_on;
         end
         in_flight = items_sent + int'(took) - results_seen;
         if (req_tvalid && !took) begin
            // hold the item until accepted
         end else if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (item_q.size() != 0 && !(item_q[0].drain && in_flight != 0)) begin
            cur_item = item_q.pop_front();
            req_tdata <= {7'd0, cur_item.present, cur_item.code};
            req_tuser <= cur_item.kind;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : watch_rsp
      result_type got;
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b1;
         recv_gap = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status       = rsp_tuser;
            got.slot         = rsp_tdata[7:0];
            got.tile_u       = rsp_tdata[15:8];
            got.tile_v       = rsp_tdata[23:16];
            got.upload_x     = rsp_tdata[29:24];
            got.raster_index = rsp_tdata[37:30];
            results_seen <= results_seen + 1;
            if (rsp_expect_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result: status %0d slot %0d", got.status, got.slot);
            end else begin
               want = rsp_expect_q.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"result %0d mismatch: expected st %0d slot %0d u %0d v %0d",
                               " ux %0d ras %0d, got st %0d slot %0d u %0d v %0d",
                               " ux %0d ras %0d"},
                              results_seen, want.status, want.slot, want.tile_u,
                              want.tile_v, want.upload_x, want.raster_index,
                              got.status, got.slot, got.tile_u, got.tile_v,
                              got.upload_x, got.raster_index);
               end
            end
            recv_gap = pick_idle(recv_idle_on);
            if ($urandom_range(0, 63) == 0) recv_idle_on = !recv_idle_on;
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog: no item moving on either side for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
